// ===== sv/usbmsc_pkg.sv =====
`default_nettype none

package usbmsc_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_CLASS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_SUBCLASS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_PROTOCOL = 2'd2;

    localparam logic [7:0] RESET_MATCH_CLASS    = 8'd8;
    localparam logic [7:0] RESET_MATCH_SUBCLASS = 8'd6;
    localparam logic [7:0] RESET_MATCH_PROTOCOL = 8'd80;

    localparam logic [3:0] MIN_HEADER     = 4'd9;
    localparam logic [7:0] MIN_IF_LENGTH  = 8'd9;
    localparam logic [7:0] MIN_EP_LENGTH  = 8'd7;
    localparam logic [7:0] MIN_LENGTH     = 8'd2;
    localparam logic [7:0] TYPE_CONFIG    = 8'd2;
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [1:0] XFER_BULK      = 2'd2;
    localparam int unsigned DIR_IN_BIT    = 7;
    localparam int unsigned DESC_BYTES    = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  configuration_value;
        logic [7:0]  interface_number;
        logic [7:0]  in_endpoint_address;
        logic [4:0]  in_endpoint_id;
        logic [10:0] in_max_packet;
        logic [7:0]  out_endpoint_address;
        logic [4:0]  out_endpoint_id;
        logic [10:0] out_max_packet;
    } out_t;

    typedef struct packed {
        logic [7:0]  address;
        logic [4:0]  id;
        logic [10:0] max_packet;
    } ep_t;

endpackage

`default_nettype wire

// ===== sv/usb_msc_descriptor_parser.sv =====
// Latency: a result appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while the input is not stalled; each byte is decoded in a single pass from
// the walk registers into the held fields and the output register.
// Input stalls only while a result waits in the output register.
// Reset: asynchronous, active low; clears the walk, held fields and output
// valid, and loads the match registers with 8, 6 and 80.
`default_nettype none

module usb_msc_descriptor_parser (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire usbmsc_pkg::in_t                      in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output usbmsc_pkg::out_t                          out_data,
    input  wire logic                                 cfg_write,
    input  wire logic [usbmsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                           cfg_data
);
    import usbmsc_pkg::*;

    logic [7:0] match_class_reg, match_subclass_reg, match_protocol_reg;

    logic [3:0] header_pos_reg,  header_pos_next;
    logic       type_good_reg,   type_good_next;
    logic [7:0] desc_len_reg,    desc_len_next;
    logic [7:0] desc_pos_reg,    desc_pos_next;
    logic [7:0] desc_type_reg,   desc_type_next;
    logic       walk_stopped_reg, walk_stopped_next;
    logic       inside_match_reg, inside_match_next;
    logic [7:0] held_config_reg, held_config_next;
    logic [7:0] held_if_reg,     held_if_next;
    ep_t        held_in_reg,     held_in_next;
    ep_t        held_out_reg,    held_out_next;
    logic       out_valid_reg;
    out_t       out_data_reg,    out_data_next;

    logic [7:0] desc_bytes_reg [DESC_BYTES];

    logic       accept;
    logic       byte_wr;
    logic [2:0] byte_idx;

    logic [3:0] header_pos_upd;
    logic       type_good_upd;
    logic [7:0] held_config_upd;
    logic       inside_match_upd;
    logic [7:0] held_if_upd;
    ep_t        held_in_upd, held_out_upd;
    logic       done;
    logic       is_if, is_ep, if_match, ep_bulk;
    logic [3:0] ep_num;
    logic [10:0] ep_mps;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ep_num   = desc_bytes_reg[0][3:0];
    assign ep_mps   = {desc_bytes_reg[3][2:0], desc_bytes_reg[2]};
    assign is_if    = (desc_type_reg == TYPE_INTERFACE) && (desc_len_reg >= MIN_IF_LENGTH);
    assign is_ep    = (desc_type_reg == TYPE_ENDPOINT) && (desc_len_reg >= MIN_EP_LENGTH)
                      && inside_match_reg;
    assign if_match = (desc_bytes_reg[3] == match_class_reg)
                      && (desc_bytes_reg[4] == match_subclass_reg)
                      && (desc_bytes_reg[5] == match_protocol_reg);
    assign ep_bulk  = (desc_bytes_reg[1][1:0] == XFER_BULK) && (ep_num != 4'd0);

    assign byte_wr  = !walk_stopped_reg && (desc_pos_reg >= 8'd2) && (desc_pos_reg < 8'd8);
    assign byte_idx = 3'(desc_pos_reg - 8'd2);

    always_comb
    begin
        header_pos_upd  = header_pos_reg;
        type_good_upd   = type_good_reg;
        held_config_upd = held_config_reg;
        if (header_pos_reg == 4'd1)
        begin
            type_good_upd = (in_data.data_byte == TYPE_CONFIG);
        end
        if (header_pos_reg == 4'd5)
        begin
            held_config_upd = in_data.data_byte;
        end
        if (header_pos_reg < MIN_HEADER)
        begin
            header_pos_upd = header_pos_reg + 4'd1;
        end

        desc_len_next     = desc_len_reg;
        desc_pos_next     = desc_pos_reg;
        desc_type_next    = desc_type_reg;
        walk_stopped_next = walk_stopped_reg;
        inside_match_upd  = inside_match_reg;
        held_if_upd       = held_if_reg;
        held_in_upd       = held_in_reg;
        held_out_upd      = held_out_reg;
        done              = 1'b0;

        if (!walk_stopped_reg)
        begin
            if (desc_pos_reg == 8'd0)
            begin
                desc_len_next = in_data.data_byte;
                if (in_data.data_byte < MIN_LENGTH)
                begin
                    walk_stopped_next = 1'b1;
                end
            end
            else
            begin
                if (desc_pos_reg == 8'd1)
                begin
                    desc_type_next = in_data.data_byte;
                end
                done = ({1'b0, desc_pos_reg} + 9'd1) == {1'b0, desc_len_reg};
            end

            if (done)
            begin
                desc_pos_next = 8'd0;
                if (is_if)
                begin
                    inside_match_upd = if_match;
                    if (if_match)
                    begin
                        held_if_upd = desc_bytes_reg[0];
                    end
                end
                else if (is_ep && ep_bulk)
                begin
                    if (desc_bytes_reg[0][DIR_IN_BIT])
                    begin
                        held_in_upd = '{address: desc_bytes_reg[0], id: {ep_num, 1'b1},
                                        max_packet: ep_mps};
                    end
                    else
                    begin
                        held_out_upd = '{address: desc_bytes_reg[0], id: {ep_num, 1'b0},
                                         max_packet: ep_mps};
                    end
                end
            end
            else if (!walk_stopped_next)
            begin
                desc_pos_next = desc_pos_reg + 8'd1;
            end
        end

        out_data_next = '0;
        if ((header_pos_upd >= MIN_HEADER) && type_good_upd)
        begin
            out_data_next.ok = (held_config_upd != 8'd0)
                               && (held_in_upd.id != 5'd0) && (held_out_upd.id != 5'd0)
                               && (held_in_upd.max_packet != 11'd0)
                               && (held_out_upd.max_packet != 11'd0);
            out_data_next.configuration_value  = held_config_upd;
            out_data_next.interface_number     = held_if_upd;
            out_data_next.in_endpoint_address  = held_in_upd.address;
            out_data_next.in_endpoint_id       = held_in_upd.id;
            out_data_next.in_max_packet        = held_in_upd.max_packet;
            out_data_next.out_endpoint_address = held_out_upd.address;
            out_data_next.out_endpoint_id      = held_out_upd.id;
            out_data_next.out_max_packet       = held_out_upd.max_packet;
        end

        header_pos_next   = header_pos_upd;
        type_good_next    = type_good_upd;
        held_config_next  = held_config_upd;
        inside_match_next = inside_match_upd;
        held_if_next      = held_if_upd;
        held_in_next      = held_in_upd;
        held_out_next     = held_out_upd;

        // drop the walk and held stream state once the set has ended
        if (in_data.last)
        begin
            header_pos_next   = '0;
            type_good_next    = 1'b0;
            desc_len_next     = '0;
            desc_pos_next     = '0;
            desc_type_next    = '0;
            walk_stopped_next = 1'b0;
            inside_match_next = 1'b0;
            held_config_next  = '0;
            held_if_next      = '0;
            held_in_next      = '0;
            held_out_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_class_reg    <= RESET_MATCH_CLASS;
            match_subclass_reg <= RESET_MATCH_SUBCLASS;
            match_protocol_reg <= RESET_MATCH_PROTOCOL;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MATCH_CLASS:    match_class_reg    <= cfg_data;
                CFG_MATCH_SUBCLASS: match_subclass_reg <= cfg_data;
                CFG_MATCH_PROTOCOL: match_protocol_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg   <= '0;
            type_good_reg    <= 1'b0;
            desc_len_reg     <= '0;
            desc_pos_reg     <= '0;
            desc_type_reg    <= '0;
            walk_stopped_reg <= 1'b0;
            inside_match_reg <= 1'b0;
            held_config_reg  <= '0;
            held_if_reg      <= '0;
            held_in_reg      <= '0;
            held_out_reg     <= '0;
        end
        else if (accept)
        begin
            header_pos_reg   <= header_pos_next;
            type_good_reg    <= type_good_next;
            desc_len_reg     <= desc_len_next;
            desc_pos_reg     <= desc_pos_next;
            desc_type_reg    <= desc_type_next;
            walk_stopped_reg <= walk_stopped_next;
            inside_match_reg <= inside_match_next;
            held_config_reg  <= held_config_next;
            held_if_reg      <= held_if_next;
            held_in_reg      <= held_in_next;
            held_out_reg     <= held_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_wr)
        begin
            desc_bytes_reg[byte_idx] <= in_data.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && in_data.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last |=> out_valid)
        else $error("last byte accepted without a result word");

    a_last_clears_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last |=> (header_pos_reg == 4'd0) && !walk_stopped_reg
                                   && (desc_pos_reg == 8'd0))
        else $error("stream state not cleared after last byte");

    a_header_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        header_pos_reg <= MIN_HEADER)
        else $error("header position beyond its limit");

    a_stopped_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        walk_stopped_reg && accept && !in_data.last |=> $stable(desc_pos_reg))
        else $error("descriptor position moved after the walk stopped");

    a_ok_ids: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ok |-> out_data.in_endpoint_id[0]
                                     && !out_data.out_endpoint_id[0])
        else $error("endpoint id direction bit wrong in a good result");

endmodule

`default_nettype wire

// ===== test/tb_usb_msc_descriptor_parser.sv =====
`default_nettype none

module tb_usb_msc_descriptor_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import usbmsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 5;
    localparam int BYTES_PER_PHASE = 330;
    localparam int MAX_GAP = 18;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [3:0] EP_NUM_MASK = 4'hf;

    typedef enum int {PICK_IFACE, PICK_EP_IN, PICK_EP_OUT, PICK_OTHER, PICK_NOISE} desc_pick_t;

    class descriptor_scoreboard;
        logic [7:0] match_class = RESET_MATCH_CLASS;
        logic [7:0] match_subclass = RESET_MATCH_SUBCLASS;
        logic [7:0] match_protocol = RESET_MATCH_PROTOCOL;

        logic [3:0] hdr_count = '0;
        bit         type_ok = 0;
        logic [7:0] desc_len = '0;
        logic [7:0] desc_pos = '0;
        logic [7:0] desc_kind = '0;
        logic [7:0] desc_body [DESC_BYTES];
        bit         walk_halted = 0;
        bit         armed = 0;
        logic [7:0] cfg_value = '0;
        logic [7:0] if_number = '0;
        ep_t        in_ep = '0;
        ep_t        out_ep = '0;

        out_t expected_results [$];
        int mismatches = 0;
        int results_checked = 0;
        int ok_results = 0;

        function void set_match(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_MATCH_CLASS:    match_class = val;
                CFG_MATCH_SUBCLASS: match_subclass = val;
                CFG_MATCH_PROTOCOL: match_protocol = val;
                default: ;
            endcase
        endfunction

        function void close_descriptor();
            logic [3:0]  num;
            logic [10:0] mps;
            num = desc_body[0][3:0] & EP_NUM_MASK;
            mps = {desc_body[3][2:0], desc_body[2]};
            if (desc_kind == TYPE_INTERFACE && desc_len >= MIN_IF_LENGTH)
            begin
                armed = desc_body[3] == match_class && desc_body[4] == match_subclass &&
                        desc_body[5] == match_protocol;
                if (armed)
                    if_number = desc_body[0];
            end
            else if (desc_kind == TYPE_ENDPOINT && desc_len >= MIN_EP_LENGTH && armed)
            begin
                if (desc_body[1][1:0] == XFER_BULK && num != 0)
                begin
                    if (desc_body[0][DIR_IN_BIT])
                        in_ep = '{address: desc_body[0], id: {num, 1'b1}, max_packet: mps};
                    else
                        out_ep = '{address: desc_body[0], id: {num, 1'b0}, max_packet: mps};
                end
            end
        endfunction

        function void note_byte(in_t w);
            logic [7:0] b;
            logic [7:0] pos;
            bit done;
            out_t r;
            b = w.data_byte;
            if (hdr_count == 1)
                type_ok = b == TYPE_CONFIG;
            if (hdr_count == 5)
                cfg_value = b;
            if (hdr_count < MIN_HEADER)
                hdr_count++;
            if (!walk_halted)
            begin
                pos = desc_pos;
                done = 0;
                if (pos == 0)
                begin
                    desc_len = b;
                    if (b < MIN_LENGTH)
                        walk_halted = 1;
                end
                else
                begin
                    if (pos == 1)
                        desc_kind = b;
                    else if (pos < 8)
                        desc_body[int'(pos) - 2] = b;
                    if (int'(pos) + 1 == int'(desc_len))
                        done = 1;
                end
                if (done)
                begin
                    close_descriptor();
                    desc_pos = '0;
                end
                else if (!walk_halted)
                    desc_pos = pos + 8'd1;
            end
            if (w.last)
            begin
                r = '0;
                if (hdr_count >= MIN_HEADER && type_ok)
                begin
                    r.ok = cfg_value != 0 && in_ep.id != 0 && out_ep.id != 0 &&
                           in_ep.max_packet != 0 && out_ep.max_packet != 0;
                    r.configuration_value = cfg_value;
                    r.interface_number = if_number;
                    r.in_endpoint_address = in_ep.address;
                    r.in_endpoint_id = in_ep.id;
                    r.in_max_packet = in_ep.max_packet;
                    r.out_endpoint_address = out_ep.address;
                    r.out_endpoint_id = out_ep.id;
                    r.out_max_packet = out_ep.max_packet;
                end
                expected_results.push_back(r);
                hdr_count = '0;
                type_ok = 0;
                desc_len = '0;
                desc_pos = '0;
                desc_kind = '0;
                foreach (desc_body[i])
                    desc_body[i] = '0;
                walk_halted = 0;
                armed = 0;
                cfg_value = '0;
                if_number = '0;
                in_ep = '0;
                out_ep = '0;
            end
        endfunction

        function string show(out_t r);
            return $sformatf("ok=%0d cfg=%02h if=%02h in=%02h/%0d/%0d out=%02h/%0d/%0d",
                             r.ok, r.configuration_value, r.interface_number,
                             r.in_endpoint_address, r.in_endpoint_id, r.in_max_packet,
                             r.out_endpoint_address, r.out_endpoint_id, r.out_max_packet);
        endfunction

        function void check_result(out_t got);
            out_t want;
            string bad;
            bad = "";
            results_checked++;
            if (got.ok === 1'b1)
                ok_results++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok) bad = {bad, " ok"};
            if (got.configuration_value !== want.configuration_value) bad = {bad, " cfg"};
            if (got.interface_number !== want.interface_number) bad = {bad, " if"};
            if (got.in_endpoint_address !== want.in_endpoint_address) bad = {bad, " in_addr"};
            if (got.in_endpoint_id !== want.in_endpoint_id) bad = {bad, " in_id"};
            if (got.in_max_packet !== want.in_max_packet) bad = {bad, " in_mps"};
            if (got.out_endpoint_address !== want.out_endpoint_address) bad = {bad, " out_addr"};
            if (got.out_endpoint_id !== want.out_endpoint_id) bad = {bad, " out_id"};
            if (got.out_max_packet !== want.out_max_packet) bad = {bad, " out_mps"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on%s\n  expected %s\n  actual   %s",
                             bad, show(want), show(got));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    descriptor_scoreboard sb;
    logic [7:0] set_bytes [$];
    bit quiet = 0;
    int sets_sent = 0;
    int bytes_sent = 0;

    usb_msc_descriptor_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("usb_msc_descriptor_parser regression: fail");
        $finish;
    end

    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(out_data);
        end
    end

    task automatic send_word(in_t w, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_byte(w);
        bytes_sent++;
    endtask

    task automatic send_set();
        in_t w;
        for (int i = 0; i < set_bytes.size(); i++)
        begin
            w.data_byte = set_bytes[i];
            w.last = i == set_bytes.size() - 1;
            send_word(w, quiet ? 0 : $urandom_range(0, MAX_GAP));
        end
        sets_sent++;
    endtask

    task automatic apply_matches(logic [7:0] c, logic [7:0] s, logic [7:0] p, bit poke);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [7:0] val [4];
        idx = '{CFG_MATCH_CLASS, CFG_MATCH_SUBCLASS, CFG_MATCH_PROTOCOL, CFG_UNUSED};
        val = '{c, s, p, 8'h00};
        val[3] = 8'($urandom);
        for (int i = 0; i < (poke ? 4 : 3); i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            sb.set_match(idx[i], val[i]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic push_desc(desc_pick_t pick, bit canonical);
        logic [7:0] d [12];
        int len;
        logic [3:0] num;
        foreach (d[i])
            d[i] = 8'($urandom);
        case (pick)
            PICK_IFACE:
            begin
                len = (canonical || $urandom_range(0, 7) != 0) ? 9 : $urandom_range(2, 12);
                d[1] = TYPE_INTERFACE;
                d[5] = sb.match_class;
                d[6] = sb.match_subclass;
                d[7] = sb.match_protocol;
                if (!canonical)
                    case ($urandom_range(0, 5))
                        0: d[5] = 8'($urandom);
                        1: d[6] = 8'($urandom);
                        2: d[7] = 8'($urandom);
                        default: ;
                    endcase
            end
            PICK_EP_IN, PICK_EP_OUT:
            begin
                len = (canonical || $urandom_range(0, 7) != 0) ? 7 : $urandom_range(2, 10);
                d[1] = TYPE_ENDPOINT;
                num = (!canonical && $urandom_range(0, 5) == 0) ? 4'd0
                                                                : 4'($urandom_range(1, 15));
                d[2] = {pick == PICK_EP_IN, d[2][6:4], num};
                if (canonical || $urandom_range(0, 4) != 0)
                    d[3][1:0] = XFER_BULK;
                if (!canonical && $urandom_range(0, 9) == 0)
                    {d[5][2:0], d[4]} = 11'd0;
            end
            PICK_OTHER:
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 80)
                                                   : $urandom_range(2, 20);
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    set_bytes.push_back(8'($urandom_range(0, 1)));
                else
                    repeat ($urandom_range(1, 4)) set_bytes.push_back(8'($urandom));
                return;
            end
        endcase
        d[0] = 8'(len);
        for (int i = 0; i < len; i++)
            set_bytes.push_back(i < 12 ? d[i] : 8'($urandom));
    endtask

    task automatic gen_set();
        int kind;
        int n;
        bit canonical;
        logic [7:0] v;
        set_bytes.delete();
        kind = $urandom_range(0, 19);
        canonical = kind >= 8;
        v = (kind == 0) ? 8'($urandom_range(0, 255)) : 8'd9;
        set_bytes.push_back(v);
        v = (kind == 1) ? 8'($urandom_range(0, 255)) : TYPE_CONFIG;
        set_bytes.push_back(v);
        repeat (3) set_bytes.push_back(8'($urandom));
        v = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        set_bytes.push_back(v);
        repeat (3) set_bytes.push_back(8'($urandom));
        if (kind == 2)
        begin
            n = $urandom_range(1, 8);
            while (set_bytes.size() > n)
                void'(set_bytes.pop_back());
            return;
        end
        if (canonical)
        begin
            if ($urandom_range(0, 1) == 1)
                push_desc(PICK_OTHER, 0);
            push_desc(PICK_IFACE, 1);
            if ($urandom_range(0, 1) == 1)
            begin
                push_desc(PICK_EP_IN, 1);
                push_desc(PICK_EP_OUT, 1);
            end
            else
            begin
                push_desc(PICK_EP_OUT, 1);
                push_desc(PICK_EP_IN, 1);
            end
            if ($urandom_range(0, 2) == 0)
                push_desc(desc_pick_t'($urandom_range(0, 4)), 0);
        end
        else
            repeat ($urandom_range(1, 8)) push_desc(desc_pick_t'($urandom_range(0, 4)), 0);
        // cut the tail to leave a descriptor unfinished
        if ($urandom_range(0, 7) == 0 && set_bytes.size() > 1)
        begin
            n = $urandom_range(1, set_bytes.size() > 6 ? 5 : set_bytes.size() - 1);
            repeat (n) void'(set_bytes.pop_back());
        end
    endtask

    initial
    begin
        int phase_bytes;
        logic [7:0] rc;
        logic [7:0] rs;
        logic [7:0] rp;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_bytes = '{8'h00};
        send_set();
        set_bytes = '{8'hff};
        send_set();
        set_bytes = '{8'hff, 8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_set();
        set_bytes = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_set();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                in_valid <= 1'b0;
                while (sb.expected_results.size() != 0) @(posedge clk);
                repeat (4) @(posedge clk);
                rc = 8'($urandom);
                rs = 8'($urandom);
                rp = 8'($urandom);
                case (phase)
                    1: apply_matches(8'h00, 8'h00, 8'h00, 0);
                    2: apply_matches(8'hff, 8'hff, 8'hff, 0);
                    3: apply_matches(rc, rs, rp, 1);
                    default: apply_matches(RESET_MATCH_CLASS, RESET_MATCH_SUBCLASS,
                                           RESET_MATCH_PROTOCOL, 0);
                endcase
            end
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE)
            begin
                quiet = $urandom_range(0, 4) == 0;
                gen_set();
                send_set();
                phase_bytes += set_bytes.size();
            end
        end
        in_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("sent %0d descriptor sets (%0d bytes) under %0d match settings",
                 sets_sent, bytes_sent, PHASES);
        $display("checked %0d results, %0d of them with a usable bulk pair, %0d mismatches",
                 sb.results_checked, sb.ok_results, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("usb_msc_descriptor_parser regression: pass");
        else
            $display("usb_msc_descriptor_parser regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
